FILE: sv/fpgd_pkg.sv
// Shared types and constants for the four-point group dispersion block.
package fpgd_pkg;

	localparam int unsigned X_W      = 10;
	localparam int unsigned Y_W      = 9;
	localparam int unsigned DIST_W   = 10;
	localparam int unsigned NPTS     = 4;
	localparam int unsigned SUMX_W   = X_W + 2;
	localparam int unsigned SUMY_W   = Y_W + 2;
	localparam int unsigned SQ_W     = 2 * DIST_W;
	localparam int unsigned ACC_W    = SQ_W + 1;
	localparam int unsigned ROOT_STG = DIST_W;
	localparam int unsigned NSTG     = ROOT_STG + 3;
	localparam int unsigned LAST_STG = NSTG - 1;

	typedef logic [X_W-1:0]    x_t;
	typedef logic [Y_W-1:0]    y_t;
	typedef logic [DIST_W-1:0] dist_t;

	typedef struct packed {
		x_t point0_x;
		y_t point0_y;
		x_t point1_x;
		y_t point1_y;
		x_t point2_x;
		y_t point2_y;
		x_t point3_x;
		y_t point3_y;
	} in_word_t;

	typedef struct packed {
		x_t    center_x;
		y_t    center_y;
		dist_t spread_max;
		dist_t error0;
		dist_t error1;
		dist_t error2;
		dist_t error3;
	} out_word_t;

endpackage

FILE: sv/four_point_group_dispersion.sv
// Top level of the four-point group dispersion block: centroid, four distance lanes, merge.
//
//   channel  | handshake             | word
//   ---------+-----------------------+--------------------------------
//   in       | in_valid / in_ready   | in_word  (fpgd_pkg::in_word_t)
//   out      | out_valid / out_ready | out_word (fpgd_pkg::out_word_t)
//
// One word accepted per cycle while in_ready is high; each result passes through
// 13 register stages: one centroid stage, one squaring stage, ten root stages
// (one result bit each), one merge stage.
// Reset clears only the stage valid bits.
// Each stage advances when empty or when the stage after it advances, so bubbles close up
// and in_ready stays high while out_word waits as long as any stage is empty.
module four_point_group_dispersion (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fpgd_pkg::in_word_t   in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fpgd_pkg::out_word_t  out_word
);

	logic [fpgd_pkg::NSTG-1:0] vld_q;
	logic [fpgd_pkg::NSTG:0]   en;

	fpgd_pkg::in_word_t pts_s0;
	fpgd_pkg::x_t       cx_s0;
	fpgd_pkg::y_t       cy_s0;
	fpgd_pkg::x_t       px [fpgd_pkg::NPTS];
	fpgd_pkg::y_t       py [fpgd_pkg::NPTS];
	fpgd_pkg::dist_t    len [fpgd_pkg::NPTS];

	assign en[fpgd_pkg::NSTG] = out_ready;
	for (genvar k = 0; k < fpgd_pkg::NSTG; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < fpgd_pkg::NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= (k == 0) ? in_valid : vld_q[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[fpgd_pkg::LAST_STG];

	fpgd_center u_center (
		.clk     (clk),
		.en      (en[0]),
		.in_word (in_word),
		.pts_s0  (pts_s0),
		.cx_s0   (cx_s0),
		.cy_s0   (cy_s0)
	);

	assign px[0] = pts_s0.point0_x;
	assign py[0] = pts_s0.point0_y;
	assign px[1] = pts_s0.point1_x;
	assign py[1] = pts_s0.point1_y;
	assign px[2] = pts_s0.point2_x;
	assign py[2] = pts_s0.point2_y;
	assign px[3] = pts_s0.point3_x;
	assign py[3] = pts_s0.point3_y;

	for (genvar i = 0; i < fpgd_pkg::NPTS; i++) begin : g_lane
		fpgd_lane u_lane (
			.clk  (clk),
			.en   (en[fpgd_pkg::ROOT_STG+1:1]),
			.px   (px[i]),
			.py   (py[i]),
			.cx   (cx_s0),
			.cy   (cy_s0),
			.len  (len[i])
		);
	end

	fpgd_merge u_merge (
		.clk      (clk),
		.en       (en[fpgd_pkg::LAST_STG:1]),
		.cx       (cx_s0),
		.cy       (cy_s0),
		.len      (len),
		.out_word (out_word)
	);

endmodule

FILE: sv/fpgd_center.sv
// Input register stage: capture the points and compute the truncated centroid.
module fpgd_center (
	input  logic                clk,
	input  logic                en,
	input  fpgd_pkg::in_word_t  in_word,
	output fpgd_pkg::in_word_t  pts_s0,
	output fpgd_pkg::x_t        cx_s0,
	output fpgd_pkg::y_t        cy_s0
);

	logic [fpgd_pkg::SUMX_W-1:0] sum_x;
	logic [fpgd_pkg::SUMY_W-1:0] sum_y;

	assign sum_x = fpgd_pkg::SUMX_W'(in_word.point0_x) + fpgd_pkg::SUMX_W'(in_word.point1_x)
		+ fpgd_pkg::SUMX_W'(in_word.point2_x) + fpgd_pkg::SUMX_W'(in_word.point3_x);
	assign sum_y = fpgd_pkg::SUMY_W'(in_word.point0_y) + fpgd_pkg::SUMY_W'(in_word.point1_y)
		+ fpgd_pkg::SUMY_W'(in_word.point2_y) + fpgd_pkg::SUMY_W'(in_word.point3_y);

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s0 <= in_word;
			cx_s0  <= sum_x[fpgd_pkg::SUMX_W-1:2];
			cy_s0  <= sum_y[fpgd_pkg::SUMY_W-1:2];
		end
	end

endmodule

FILE: sv/fpgd_lane.sv
// Distance lane: squared offset from the centroid, then a pipelined restoring square root.
module fpgd_lane (
	input  logic                           clk,
	input  logic [fpgd_pkg::ROOT_STG:0]    en,
	input  fpgd_pkg::x_t                   px,
	input  fpgd_pkg::y_t                   py,
	input  fpgd_pkg::x_t                   cx,
	input  fpgd_pkg::y_t                   cy,
	output fpgd_pkg::dist_t                len
);

	fpgd_pkg::x_t              dx;
	fpgd_pkg::y_t              dy;
	logic [fpgd_pkg::SQ_W-1:0] sq;

	logic [fpgd_pkg::SQ_W-1:0]  rem_s [0:fpgd_pkg::ROOT_STG];
	logic [fpgd_pkg::ACC_W-1:0] acc_s [0:fpgd_pkg::ROOT_STG];

	assign dx = (px >= cx) ? (px - cx) : (cx - px);
	assign dy = (py >= cy) ? (py - cy) : (cy - py);
	assign sq = fpgd_pkg::SQ_W'(dx) * fpgd_pkg::SQ_W'(dx)
		+ fpgd_pkg::SQ_W'(dy) * fpgd_pkg::SQ_W'(dy);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= sq;
			acc_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < fpgd_pkg::ROOT_STG; j++) begin : g_root
		localparam int unsigned SH = 2 * (fpgd_pkg::ROOT_STG - 1 - j);
		logic [fpgd_pkg::ACC_W-1:0] trial;
		logic                       take;

		assign trial = acc_s[j] + (fpgd_pkg::ACC_W'(1) << SH);
		assign take  = {1'b0, rem_s[j]} >= trial;

		always_ff @(posedge clk) begin
			if (en[j+1]) begin
				if (take) begin
					rem_s[j+1] <= rem_s[j] - trial[fpgd_pkg::SQ_W-1:0];
					acc_s[j+1] <= (acc_s[j] + (fpgd_pkg::ACC_W'(1) << (SH + 1))) >> 1;
				end else begin
					rem_s[j+1] <= rem_s[j];
					acc_s[j+1] <= acc_s[j] >> 1;
				end
			end
		end
	end

	assign len = acc_s[fpgd_pkg::ROOT_STG][fpgd_pkg::DIST_W-1:0];

endmodule

FILE: sv/fpgd_merge.sv
// Merge stage: carry the centroid alongside the lanes and register the result word.
module fpgd_merge (
	input  logic                           clk,
	input  logic [fpgd_pkg::ROOT_STG+1:0]  en,
	input  fpgd_pkg::x_t                   cx,
	input  fpgd_pkg::y_t                   cy,
	input  fpgd_pkg::dist_t                len [fpgd_pkg::NPTS],
	output fpgd_pkg::out_word_t            out_word
);

	fpgd_pkg::x_t    cx_s [0:fpgd_pkg::ROOT_STG];
	fpgd_pkg::y_t    cy_s [0:fpgd_pkg::ROOT_STG];
	fpgd_pkg::dist_t max01;
	fpgd_pkg::dist_t max23;
	fpgd_pkg::dist_t peak;

	for (genvar k = 0; k <= fpgd_pkg::ROOT_STG; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en[k]) begin
				cx_s[k] <= (k == 0) ? cx : cx_s[(k == 0) ? 0 : k-1];
				cy_s[k] <= (k == 0) ? cy : cy_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign max01 = (len[0] >= len[1]) ? len[0] : len[1];
	assign max23 = (len[2] >= len[3]) ? len[2] : len[3];
	assign peak  = (max01 >= max23) ? max01 : max23;

	always_ff @(posedge clk) begin
		if (en[fpgd_pkg::ROOT_STG+1]) begin
			out_word.center_x   <= cx_s[fpgd_pkg::ROOT_STG];
			out_word.center_y   <= cy_s[fpgd_pkg::ROOT_STG];
			out_word.spread_max <= peak;
			out_word.error0     <= len[0];
			out_word.error1     <= len[1];
			out_word.error2     <= len[2];
			out_word.error3     <= len[3];
		end
	end

endmodule

FILE: verif/four_point_group_dispersion_test.sv
// Self-checking testbench for four_point_group_dispersion: random point groups, stalls, scoreboard.
`timescale 1ns / 1ps

module four_point_group_dispersion_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_GROUPS  = 950;
	localparam int DRAIN_CYCLES   = 20;

	class dispersion_board;
		fpgd_pkg::out_word_t due_q[$];
		int n_words;
		int n_results;
		int n_errors;

		function int unsigned isqrt_floor(int unsigned v);
			int unsigned rem;
			int unsigned acc;
			int unsigned b;
			rem = v;
			acc = 0;
			b = 32'h4000_0000;
			while (b > rem)
				b = b >> 2;
			while (b != 0) begin
				if (rem >= acc + b) begin
					rem = rem - (acc + b);
					acc = acc + 2 * b;
				end
				acc = acc >> 1;
				b = b >> 2;
			end
			return acc;
		endfunction

		function fpgd_pkg::out_word_t predict_spread(fpgd_pkg::in_word_t w);
			fpgd_pkg::x_t px[4];
			fpgd_pkg::y_t py[4];
			logic [fpgd_pkg::SUMX_W-1:0] sx;
			logic [fpgd_pkg::SUMY_W-1:0] sy;
			fpgd_pkg::x_t cx;
			fpgd_pkg::y_t cy;
			int unsigned dx;
			int unsigned dy;
			fpgd_pkg::dist_t d[4];
			fpgd_pkg::dist_t peak;
			fpgd_pkg::out_word_t r;
			px = '{w.point0_x, w.point1_x, w.point2_x, w.point3_x};
			py = '{w.point0_y, w.point1_y, w.point2_y, w.point3_y};
			sx = '0;
			sy = '0;
			for (int i = 0; i < 4; i++) begin
				sx = sx + px[i];
				sy = sy + py[i];
			end
			cx = sx[fpgd_pkg::SUMX_W-1:2];
			cy = sy[fpgd_pkg::SUMY_W-1:2];
			peak = '0;
			for (int i = 0; i < 4; i++) begin
				dx = (px[i] >= cx) ? px[i] - cx : cx - px[i];
				dy = (py[i] >= cy) ? py[i] - cy : cy - py[i];
				d[i] = fpgd_pkg::dist_t'(isqrt_floor(dx * dx + dy * dy));
				if (d[i] > peak)
					peak = d[i];
			end
			r.center_x   = cx;
			r.center_y   = cy;
			r.spread_max = peak;
			r.error0     = d[0];
			r.error1     = d[1];
			r.error2     = d[2];
			r.error3     = d[3];
			return r;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function void note_word(fpgd_pkg::in_word_t w);
			due_q.push_back(predict_spread(w));
			n_words++;
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			n_errors++;
		endtask

		task cmp(string field, int unsigned want, int unsigned got);
			if (want != got)
				report($sformatf("result %0d %s: expected %0d, got %0d",
					n_results, field, want, got));
		endtask

		task check_word(fpgd_pkg::out_word_t got);
			fpgd_pkg::out_word_t want;
			n_results++;
			if (due_q.size() == 0) begin
				report($sformatf("result %0d arrived with nothing pending", n_results));
				return;
			end
			want = due_q.pop_front();
			cmp("center_x", want.center_x, got.center_x);
			cmp("center_y", want.center_y, got.center_y);
			cmp("spread_max", want.spread_max, got.spread_max);
			cmp("error0", want.error0, got.error0);
			cmp("error1", want.error1, got.error1);
			cmp("error2", want.error2, got.error2);
			cmp("error3", want.error3, got.error3);
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	fpgd_pkg::in_word_t  in_word;
	logic                out_valid;
	logic                out_ready;
	fpgd_pkg::out_word_t out_word;

	dispersion_board board;
	bit sink_stalls;
	int stall_cycles = 0;

	four_point_group_dispersion uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 80);
		return $urandom_range(1, 3);
	endfunction

	function automatic fpgd_pkg::in_word_t pack_group(int unsigned x0, int unsigned y0,
		int unsigned x1, int unsigned y1, int unsigned x2, int unsigned y2,
		int unsigned x3, int unsigned y3);
		fpgd_pkg::in_word_t w;
		w.point0_x = fpgd_pkg::x_t'(x0);
		w.point0_y = fpgd_pkg::y_t'(y0);
		w.point1_x = fpgd_pkg::x_t'(x1);
		w.point1_y = fpgd_pkg::y_t'(y1);
		w.point2_x = fpgd_pkg::x_t'(x2);
		w.point2_y = fpgd_pkg::y_t'(y2);
		w.point3_x = fpgd_pkg::x_t'(x3);
		w.point3_y = fpgd_pkg::y_t'(y3);
		return w;
	endfunction

	function automatic fpgd_pkg::in_word_t random_group();
		int unsigned gx[4];
		int unsigned gy[4];
		int unsigned bx;
		int unsigned by;
		int unsigned mode;
		mode = $urandom_range(0, 19);
		bx = $urandom_range(0, 784);
		by = $urandom_range(0, 464);
		for (int i = 0; i < 4; i++) begin
			if (mode < 12) begin
				gx[i] = $urandom_range(0, 799);
				gy[i] = $urandom_range(0, 479);
			end else if (mode < 15) begin
				gx[i] = $urandom_range(0, 1023);
				gy[i] = $urandom_range(0, 511);
			end else if (mode < 19) begin
				gx[i] = bx + $urandom_range(0, 15);
				gy[i] = by + $urandom_range(0, 15);
			end else begin
				gx[i] = bx;
				gy[i] = by;
			end
		end
		return pack_group(gx[0], gy[0], gx[1], gy[1], gx[2], gy[2], gx[3], gy[3]);
	endfunction

	task automatic send_word(input fpgd_pkg::in_word_t w);
		in_word <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic idle_in(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// sink: random backpressure while enabled
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_stalls && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_word(in_word);
		if (arst_n && out_valid && out_ready)
			board.check_word(out_word);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		fpgd_pkg::in_word_t dir_q[$];
		bit quiet;
		int n_directed;
		board = new();
		sink_stalls = 1'b1;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_word <= '0;

		dir_q.push_back(pack_group(0, 0, 0, 0, 0, 0, 0, 0));
		dir_q.push_back(pack_group(1023, 511, 1023, 511, 1023, 511, 1023, 511));
		dir_q.push_back(pack_group(799, 479, 799, 479, 799, 479, 799, 479));
		dir_q.push_back(pack_group(1023, 511, 0, 0, 0, 0, 0, 0));
		dir_q.push_back(pack_group(0, 0, 1023, 511, 0, 0, 0, 0));
		dir_q.push_back(pack_group(0, 0, 0, 0, 1023, 511, 0, 0));
		dir_q.push_back(pack_group(0, 0, 0, 0, 0, 0, 1023, 511));
		dir_q.push_back(pack_group(0, 0, 1023, 511, 1023, 511, 1023, 511));
		dir_q.push_back(pack_group(0, 0, 799, 0, 0, 479, 799, 479));
		dir_q.push_back(pack_group(799, 479, 0, 0, 0, 0, 0, 0));
		dir_q.push_back(pack_group(682, 341, 341, 170, 682, 341, 341, 170));
		dir_q.push_back(pack_group(341, 170, 682, 341, 341, 170, 682, 341));
		dir_q.push_back(pack_group(1, 1, 0, 0, 0, 0, 0, 0));
		dir_q.push_back(pack_group(3, 3, 0, 0, 0, 0, 0, 0));
		dir_q.push_back(pack_group(1, 1, 1, 1, 1, 1, 0, 0));
		dir_q.push_back(pack_group(1, 1, 1, 1, 1, 1, 1, 1));
		dir_q.push_back(pack_group(100, 100, 104, 100, 100, 103, 104, 103));
		dir_q.push_back(pack_group(400, 240, 400, 240, 400, 240, 403, 244));
		dir_q.push_back(pack_group(512, 256, 511, 255, 512, 256, 511, 255));
		n_directed = dir_q.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_q[i]) begin
			send_word(dir_q[i]);
			idle_in(($urandom_range(0, 2) == 0) ? gap_len() : 0);
		end

		for (int i = 0; i < RANDOM_GROUPS; i++) begin
			quiet = ((i / 100) % 3 == 1);
			sink_stalls = !quiet;
			// hold until the pipeline has fully drained
			if (i == RANDOM_GROUPS / 2) begin
				idle_in(1);
				while (board.pending() != 0)
					@(posedge clk);
			end
			send_word(random_group());
			idle_in((!quiet && $urandom_range(0, 2) == 0) ? gap_len() : 0);
		end
		in_valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d point groups (%0d directed, rest random) and %0d results,",
			board.n_words, n_directed, board.n_results);
		$display("with random input gaps, output stalls, a full drain and stall-free bursts.");
		if (board.n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
